// ----- rtl/core/rrpc_pkg.sv -----
// Shared widths, register codes and pipeline types for the rounded-rect coverage block.
package rrpc_pkg;

  localparam int COORD_W   = 13;  // pixel and centre coordinates
  localparam int DIFF_W    = 14;  // signed offsets and edge distances
  localparam int SIZE_W    = 10;  // half sizes and radius
  localparam int MASK_W    = 4;
  localparam int COV_W     = 7;
  localparam int SQ_W      = 2 * SIZE_W;       // square of a 10-bit value
  localparam int RSQ_W     = 2 * SIZE_W + 1;   // (r+1)^2 and the sum of two squares
  localparam int ROOT_W    = 32;               // root operand and partial root
  localparam int ROOT_SHIFT = 12;              // 6 fractional bits on the root
  localparam int LIMIT_W   = SIZE_W + 1 + 6;   // (r+1)*64
  localparam int ROOT_STEPS = ROOT_W / 2;
  localparam int ROOT_STEPS_PER_STAGE = 2;
  localparam int ROOT_STAGES = ROOT_STEPS / ROOT_STEPS_PER_STAGE;
  localparam int ROOT_TOP_BIT = ROOT_W - 2;
  localparam int ADDR_W    = 5;
  localparam int DATA_W    = 32;
  localparam int IDX_W     = ADDR_W - 2;

  localparam logic [COV_W-1:0] COV_ZERO = 7'd0;
  localparam logic [COV_W-1:0] COV_HALF = 7'd32;
  localparam logic [COV_W-1:0] COV_FULL = 7'd64;
  localparam logic [MASK_W-1:0] MASK_ALL_ROUND = 4'hF;

  typedef enum logic [IDX_W-1:0] {
    REG_CENTRE_X    = 3'd0,
    REG_CENTRE_Y    = 3'd1,
    REG_HALF_WIDTH  = 3'd2,
    REG_HALF_HEIGHT = 3'd3,
    REG_RADIUS      = 3'd4,
    REG_ROUND_MASK  = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [COORD_W-1:0] centre_x;
    logic [COORD_W-1:0] centre_y;
    logic [SIZE_W-1:0]  half_width;
    logic [SIZE_W-1:0]  half_height;
    logic [SIZE_W-1:0]  corner_radius;
    logic [MASK_W-1:0]  round_mask;
  } cfg_t;

  // One item in flight through the square-root stages.
  typedef struct packed {
    logic               done;   // coverage already decided
    logic [COV_W-1:0]   cov;
    logic [ROOT_W-1:0]  rem;
    logic [ROOT_W-1:0]  res;
    logic [LIMIT_W-1:0] limit;  // (r+1)*64
  } root_t;

endpackage

// ----- rtl/core/rrpc_if.sv -----
// Valid/ready channel interfaces for pixel beats and coverage beats.
interface rrpc_pix_if import rrpc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] pixel_x;
  logic [COORD_W-1:0] pixel_y;

  modport source (output valid, output pixel_x, output pixel_y, input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface rrpc_cov_if import rrpc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [COV_W-1:0] coverage;

  modport source (output valid, output coverage, input ready);
  modport sink   (input valid, input coverage, output ready);
endinterface

// ----- rtl/core/rrpc_cfg.sv -----
// APB-style configuration register file.
module rrpc_cfg import rrpc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  cfg_idx_t idx;
  logic     wr_en;

  assign idx    = cfg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_CENTRE_X:    cfg_nxt.centre_x      = pwdata[COORD_W-1:0];
        REG_CENTRE_Y:    cfg_nxt.centre_y      = pwdata[COORD_W-1:0];
        REG_HALF_WIDTH:  cfg_nxt.half_width    = pwdata[SIZE_W-1:0];
        REG_HALF_HEIGHT: cfg_nxt.half_height   = pwdata[SIZE_W-1:0];
        REG_RADIUS:      cfg_nxt.corner_radius = pwdata[SIZE_W-1:0];
        REG_ROUND_MASK:  cfg_nxt.round_mask    = pwdata[MASK_W-1:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{centre_x: '0, centre_y: '0, half_width: '0, half_height: '0,
                 corner_radius: '0, round_mask: MASK_ALL_ROUND};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    unique case (idx)
      REG_CENTRE_X:
        prdata = {{(DATA_W-COORD_W){cfg_r.centre_x[COORD_W-1]}}, cfg_r.centre_x};
      REG_CENTRE_Y:
        prdata = {{(DATA_W-COORD_W){cfg_r.centre_y[COORD_W-1]}}, cfg_r.centre_y};
      REG_HALF_WIDTH:  prdata = DATA_W'(cfg_r.half_width);
      REG_HALF_HEIGHT: prdata = DATA_W'(cfg_r.half_height);
      REG_RADIUS:      prdata = DATA_W'(cfg_r.corner_radius);
      REG_ROUND_MASK:  prdata = DATA_W'(cfg_r.round_mask);
      default:         prdata = '0;
    endcase
  end

endmodule

// ----- rtl/core/rrpc_geom.sv -----
// Geometry front end: offsets, quadrant choice, corner distances, squares and early decisions.
module rrpc_geom import rrpc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic               in_valid,
  input  logic [COORD_W-1:0] pixel_x,
  input  logic [COORD_W-1:0] pixel_y,
  input  cfg_t               cfg,
  output logic               out_valid,
  output root_t              out_item
);

  typedef struct packed {
    logic [COORD_W-1:0] dx;
    logic [COORD_W-1:0] dy;
    logic               top;
    logic               left;
    logic [SIZE_W-1:0]  r;
  } geo_a_t;

  typedef struct packed {
    logic              done;
    logic [COV_W-1:0]  cov;
    logic [SIZE_W-1:0] qx;
    logic [SIZE_W-1:0] qy;
    logic [SIZE_W-1:0] r;
  } geo_b_t;

  typedef struct packed {
    logic              done;
    logic [COV_W-1:0]  cov;
    logic [SQ_W-1:0]   sqx;
    logic [SQ_W-1:0]   sqy;
    logic [SQ_W-1:0]   rin;
    logic [RSQ_W-1:0]  rout;
    logic [SIZE_W-1:0] r;
  } geo_c_t;

  logic   a_v_r, b_v_r, c_v_r, d_v_r;
  geo_a_t a_r, a_nxt;
  geo_b_t b_r, b_nxt;
  geo_c_t c_r, c_nxt;
  root_t  d_r, d_nxt;

  // stage A: offsets from the centre and clamped radius
  logic signed [DIFF_W-1:0] sx, sy;
  logic [SIZE_W-1:0]        rmin;

  always_comb begin
    sx = {pixel_x[COORD_W-1], pixel_x} - {cfg.centre_x[COORD_W-1], cfg.centre_x};
    sy = {pixel_y[COORD_W-1], pixel_y} - {cfg.centre_y[COORD_W-1], cfg.centre_y};
    rmin = (cfg.half_width < cfg.half_height) ? cfg.half_width : cfg.half_height;
    a_nxt.dx   = sx[DIFF_W-1] ? COORD_W'(-sx) : COORD_W'(sx);
    a_nxt.dy   = sy[DIFF_W-1] ? COORD_W'(-sy) : COORD_W'(sy);
    a_nxt.top  = sy[DIFF_W-1];
    a_nxt.left = sx[DIFF_W-1];
    a_nxt.r    = (cfg.corner_radius < rmin) ? cfg.corner_radius : rmin;
  end

  // stage B: sharp-edge ramp, or distance past the inner box
  logic                     round;
  logic signed [DIFF_W-1:0] ex, ey, e;
  logic [SIZE_W-1:0]        in_x, in_y;
  logic signed [DIFF_W-1:0] qx, qy, rp1;
  logic [COV_W-1:0]         sharp_cov;

  always_comb begin
    round = cfg.round_mask[{~a_r.top, ~a_r.left}];
    ex = {{(DIFF_W-SIZE_W){1'b0}}, cfg.half_width} - {1'b0, a_r.dx};
    ey = {{(DIFF_W-SIZE_W){1'b0}}, cfg.half_height} - {1'b0, a_r.dy};
    e  = (ex < ey) ? ex : ey;
    if (e[DIFF_W-1]) begin
      sharp_cov = COV_ZERO;
    end else if (e == '0) begin
      sharp_cov = COV_HALF;
    end else begin
      sharp_cov = COV_FULL;
    end
    in_x = cfg.half_width - a_r.r;
    in_y = cfg.half_height - a_r.r;
    qx   = {1'b0, a_r.dx} - {{(DIFF_W-SIZE_W){1'b0}}, in_x};
    qy   = {1'b0, a_r.dy} - {{(DIFF_W-SIZE_W){1'b0}}, in_y};
    rp1  = {{(DIFF_W-SIZE_W){1'b0}}, a_r.r} + DIFF_W'(1);

    b_nxt.r    = a_r.r;
    b_nxt.qx   = qx[DIFF_W-1] ? '0 : qx[SIZE_W-1:0];
    b_nxt.qy   = qy[DIFF_W-1] ? '0 : qy[SIZE_W-1:0];
    b_nxt.done = 1'b1;
    b_nxt.cov  = COV_ZERO;
    if (!round) begin
      b_nxt.cov = sharp_cov;
    end else if (qx >= rp1 || qy >= rp1) begin
      b_nxt.cov = COV_ZERO;
    end else if (qx <= 0 && qy <= 0) begin
      b_nxt.cov = COV_FULL;
    end else begin
      b_nxt.done = 1'b0;
    end
  end

  // stage C: squares of the corner distance and of the ring bounds
  logic [SIZE_W-1:0] rm1;
  logic [SIZE_W:0]   rp1_c;

  always_comb begin
    rm1   = b_r.r - SIZE_W'(1);
    rp1_c = {1'b0, b_r.r} + (SIZE_W+1)'(1);
    c_nxt.done = b_r.done;
    c_nxt.cov  = b_r.cov;
    c_nxt.r    = b_r.r;
    c_nxt.sqx  = SQ_W'(b_r.qx) * SQ_W'(b_r.qx);
    c_nxt.sqy  = SQ_W'(b_r.qy) * SQ_W'(b_r.qy);
    c_nxt.rin  = (b_r.r > SIZE_W'(1)) ? SQ_W'(rm1) * SQ_W'(rm1) : '0;
    c_nxt.rout = RSQ_W'(rp1_c) * RSQ_W'(rp1_c);
  end

  // stage D: squared distance against the ring, root operand set up
  logic [RSQ_W-1:0] d2;
  logic [SIZE_W:0]  rp1_d;

  always_comb begin
    d2    = {1'b0, c_r.sqx} + {1'b0, c_r.sqy};
    rp1_d = {1'b0, c_r.r} + (SIZE_W+1)'(1);
    d_nxt.done  = c_r.done;
    d_nxt.cov   = c_r.cov;
    d_nxt.res   = '0;
    d_nxt.rem   = ROOT_W'(d2[SQ_W-1:0]) << ROOT_SHIFT;
    d_nxt.limit = {rp1_d, 6'b0};
    if (!c_r.done) begin
      if (d2 >= c_r.rout) begin
        d_nxt.done = 1'b1;
        d_nxt.cov  = COV_ZERO;
      end else if (d2 <= {1'b0, c_r.rin}) begin
        d_nxt.done = 1'b1;
        d_nxt.cov  = COV_FULL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
      d_v_r <= 1'b0;
    end else if (adv) begin
      a_v_r <= in_valid;
      b_v_r <= a_v_r;
      c_v_r <= b_v_r;
      d_v_r <= c_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_r <= a_nxt;
      b_r <= b_nxt;
      c_r <= c_nxt;
      d_r <= d_nxt;
    end
  end

  assign out_valid = d_v_r;
  assign out_item  = d_r;

endmodule

// ----- rtl/core/rrpc_root.sv -----
// Pipelined bit-pair integer square root, two result bits per stage.
module rrpc_root import rrpc_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  adv,
  input  logic  in_valid,
  input  root_t in_item,
  output logic  out_valid,
  output root_t out_item
);

  function automatic root_t root_step(root_t s, logic [ROOT_W-1:0] bit_v);
    logic [ROOT_W:0] trial;
    root_t           o;
    o     = s;
    trial = {1'b0, s.res} + {1'b0, bit_v};
    if ({1'b0, s.rem} >= trial) begin
      o.rem = s.rem - trial[ROOT_W-1:0];
      o.res = (s.res >> 1) + bit_v;
    end else begin
      o.res = s.res >> 1;
    end
    return o;
  endfunction

  logic [ROOT_STAGES-1:0] v_r;
  logic [ROOT_STAGES-1:0] v_in;
  root_t                  st_r  [ROOT_STAGES];
  root_t                  st_in [ROOT_STAGES];

  assign v_in = {v_r[ROOT_STAGES-2:0], in_valid};

  for (genvar g = 0; g < ROOT_STAGES; g++) begin : g_stage
    root_t st_nxt;

    if (g == 0) begin : g_first
      assign st_in[g] = in_item;
    end else begin : g_next
      assign st_in[g] = st_r[g-1];
    end

    always_comb begin
      st_nxt = st_in[g];
      for (int j = 0; j < ROOT_STEPS_PER_STAGE; j++) begin
        st_nxt = root_step(st_nxt,
                           ROOT_W'(1) << (ROOT_TOP_BIT - 2 * (g * ROOT_STEPS_PER_STAGE + j)));
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        st_r[g] <= st_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= v_in;
    end
  end

  assign out_valid = v_r[ROOT_STAGES-1];
  assign out_item  = st_r[ROOT_STAGES-1];

endmodule

// ----- rtl/core/rounded_rect_pixel_coverage.sv -----
// Throughput: one pixel per clock while the output is not stalled; the 16-step
// square root is spread two steps per stage over eight stages, with four geometry
// stages ahead and the output register after.
// A stall on the output freezes every stage in place; input ready follows output space.
// Reset (synchronous, rst_n low) clears all valid bits and sets the shape registers
// to zero with every corner round; no clearing pass is needed.
module rounded_rect_pixel_coverage import rrpc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  rrpc_pix_if.sink          in_pix,
  rrpc_cov_if.source        out_cov,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t  cfg;
  logic  adv;
  logic  geo_valid, root_valid;
  root_t geo_item, root_item;

  logic             out_valid_r;
  logic [COV_W-1:0] cov_r, cov_nxt;
  logic [LIMIT_W-1:0] sq;
  logic [LIMIT_W-1:0] diff;

  assign adv          = !out_valid_r || out_cov.ready;
  assign in_pix.ready = adv;

  rrpc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rrpc_geom u_geom (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (in_pix.valid),
    .pixel_x   (in_pix.pixel_x),
    .pixel_y   (in_pix.pixel_y),
    .cfg       (cfg),
    .out_valid (geo_valid),
    .out_item  (geo_item)
  );

  rrpc_root u_root (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (geo_valid),
    .in_item   (geo_item),
    .out_valid (root_valid),
    .out_item  (root_item)
  );

  // ramp across the ring: half of ((r+1)*64 - root), clamped to full
  always_comb begin
    sq   = root_item.res[LIMIT_W-1:0];
    diff = (root_item.limit - sq) >> 1;
    if (root_item.done) begin
      cov_nxt = root_item.cov;
    end else if (sq >= root_item.limit) begin
      cov_nxt = COV_ZERO;
    end else if (diff > LIMIT_W'(COV_FULL)) begin
      cov_nxt = COV_FULL;
    end else begin
      cov_nxt = diff[COV_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= root_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cov_r <= cov_nxt;
    end
  end

  assign out_cov.valid    = out_valid_r;
  assign out_cov.coverage = cov_r;

endmodule

// ----- rtl/core/rrpc_chk.sv -----
// Port-level checker for the coverage block and its bind.
module rrpc_chk import rrpc_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [COV_W-1:0] out_coverage
);

  // a beat waiting on the output stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output beat dropped while stalled");

  // payload of a stalled beat does not change
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_coverage))
    else $error("output coverage changed while stalled");

  // input side opens exactly when the output register has room
  a_ready_link: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not track output space");

  a_cov_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_coverage <= COV_FULL)
    else $error("coverage above full scale");

  a_reset_empty: assert property (@(posedge clk)
    $rose(rst_n) |-> !out_valid)
    else $error("output valid right after reset");

endmodule

bind rounded_rect_pixel_coverage rrpc_chk u_rrpc_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_pix.ready),
  .out_valid    (out_cov.valid),
  .out_ready    (out_cov.ready),
  .out_coverage (out_cov.coverage)
);

// ----- tb/rrpc_cov_checker.sv -----
// Checker: mirrors the shape registers, predicts each pixel's coverage and compares beats.
module rrpc_cov_checker import rrpc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  rrpc_pix_if               pix,
  rrpc_cov_if               cov,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output int                fails,
  output int                pending
);

  localparam logic [MASK_W-1:0] CORNER_TL = 4'b0001;
  localparam logic [MASK_W-1:0] CORNER_TR = 4'b0010;
  localparam logic [MASK_W-1:0] CORNER_BL = 4'b0100;
  localparam logic [MASK_W-1:0] CORNER_BR = 4'b1000;
  localparam longint HALF_COV = 32;
  localparam longint FULL_COV = 64;

  typedef struct {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COV_W-1:0]   coverage;
  } cov_expect_t;

  cfg_t        shape;
  cov_expect_t expected_cov_q[$];
  cov_expect_t head;

  // floor of the square root, one result bit per pass
  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = 16; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  function automatic logic [COV_W-1:0] pixel_coverage(cfg_t c, logic [COORD_W-1:0] px,
                                                      logic [COORD_W-1:0] py);
    longint ox, oy, ax, ay, hw, hh, rad, ex, ey, lin, qx, qy, d2, r_lo, r_hi;
    longint unsigned root, span;
    logic [MASK_W-1:0] quad;
    ox = longint'($signed(px)) - longint'($signed(c.centre_x));
    oy = longint'($signed(py)) - longint'($signed(c.centre_y));
    ax = (ox < 0) ? -ox : ox;
    ay = (oy < 0) ? -oy : oy;
    hw = longint'(c.half_width);
    hh = longint'(c.half_height);
    rad = longint'(c.corner_radius);
    if (rad > hw) rad = hw;
    if (rad > hh) rad = hh;
    // offset 0 falls on the bottom / right side
    quad = (oy < 0) ? ((ox < 0) ? CORNER_TL : CORNER_TR)
                    : ((ox < 0) ? CORNER_BL : CORNER_BR);
    if ((c.round_mask & quad) == '0) begin
      ex = hw - ax;
      ey = hh - ay;
      lin = HALF_COV + HALF_COV * ((ex < ey) ? ex : ey);
      if (lin <= 0) return COV_ZERO;
      if (lin >= FULL_COV) return COV_FULL;
      return COV_W'(lin);
    end
    // distance beyond the box shrunk by the radius
    qx = ax - (hw - rad);
    qy = ay - (hh - rad);
    if (qx > rad || qy > rad) return COV_ZERO;
    if (qx <= 0 && qy <= 0) return COV_FULL;
    if (qx < 0) qx = 0;
    if (qy < 0) qy = 0;
    d2 = qx * qx + qy * qy;
    r_lo = (rad > 1) ? (rad - 1) * (rad - 1) : 0;
    r_hi = (rad + 1) * (rad + 1);
    if (d2 >= r_hi) return COV_ZERO;
    if (d2 <= r_lo) return COV_FULL;
    root = floor_sqrt($unsigned(d2) << ROOT_SHIFT);
    span = $unsigned(rad + 1) * FULL_COV;
    if (root >= span) return COV_ZERO;
    span = (span - root) / 2;
    return (span > FULL_COV) ? COV_FULL : COV_W'(span);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      shape.centre_x      = '0;
      shape.centre_y      = '0;
      shape.half_width    = '0;
      shape.half_height   = '0;
      shape.corner_radius = '0;
      shape.round_mask    = MASK_ALL_ROUND;
      expected_cov_q.delete();
      fails   = 0;
      pending = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[ADDR_W-1:2])
          REG_CENTRE_X:    shape.centre_x      = pwdata[COORD_W-1:0];
          REG_CENTRE_Y:    shape.centre_y      = pwdata[COORD_W-1:0];
          REG_HALF_WIDTH:  shape.half_width    = pwdata[SIZE_W-1:0];
          REG_HALF_HEIGHT: shape.half_height   = pwdata[SIZE_W-1:0];
          REG_RADIUS:      shape.corner_radius = pwdata[SIZE_W-1:0];
          REG_ROUND_MASK:  shape.round_mask    = pwdata[MASK_W-1:0];
          default: ;
        endcase
      end
      if (pix.valid && pix.ready)
        expected_cov_q.push_back('{pix.pixel_x, pix.pixel_y,
                                   pixel_coverage(shape, pix.pixel_x, pix.pixel_y)});
      if (cov.valid && cov.ready) begin
        if (expected_cov_q.size() == 0) begin
          fails++;
          $display("%0t coverage beat with nothing pending: expected none, actual %0d",
                   $time, cov.coverage);
        end else begin
          head = expected_cov_q.pop_front();
          if (cov.coverage !== head.coverage) begin
            fails++;
            $display("%0t coverage mismatch at pixel (%0d,%0d): expected %0d, actual %0d",
                     $time, $signed(head.x), $signed(head.y), head.coverage, cov.coverage);
          end
        end
      end
      pending = expected_cov_q.size();
    end
  end

endmodule

// ----- tb/rounded_rect_pixel_coverage_test.sv -----
// Top of the coverage testbench: clock, reset, pixel stimulus, register writes and verdict.
module rounded_rect_pixel_coverage_test import rrpc_pkg::*;;

  localparam logic [IDX_W-1:0] REG_SPARE_LO = IDX_W'(REG_ROUND_MASK) + 1'b1;
  localparam logic [IDX_W-1:0] REG_SPARE_HI = REG_SPARE_LO + 1'b1;

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  int                fails;
  int                pending;
  int                send_idle_pct;
  int                recv_idle_pct;
  cfg_t              cur;

  rrpc_pix_if pix ();
  rrpc_cov_if cov ();

  rounded_rect_pixel_coverage i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_pix  (pix),
    .out_cov (cov),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  rrpc_cov_checker i_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .pix     (pix),
    .cov     (cov),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .pready  (pready),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .fails   (fails),
    .pending (pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #2_000_000;
    $display("rounded_rect_pixel_coverage_test: FAIL");
    $finish;
  end

  // result side stalls per cycle
  initial begin
    cov.ready <= 1'b0;
    forever begin
      @(posedge clk);
      cov.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_pixel(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
    int gap;
    gap = 0;
    while (gap < 8 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      pix.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix.valid   <= 1'b1;
    pix.pixel_x <= x;
    pix.pixel_y <= y;
    do @(posedge clk); while (!pix.ready);
  endtask

  task automatic send_offset(input int ox, input int oy);
    send_pixel(COORD_W'(int'($signed(cur.centre_x)) + ox),
               COORD_W'(int'($signed(cur.centre_y)) + oy));
  endtask

  // stop sending and wait until every pending coverage beat is back
  task automatic drain();
    pix.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  // junk in the unused upper bits must be dropped; spare indexes must be ignored
  task automatic apply_cfg(input cfg_t c);
    logic [DATA_W-1:0] w;
    w = $urandom; w[COORD_W-1:0] = c.centre_x;     cfg_write(REG_CENTRE_X, w);
    w = $urandom; w[COORD_W-1:0] = c.centre_y;     cfg_write(REG_CENTRE_Y, w);
    w = $urandom; w[SIZE_W-1:0]  = c.half_width;   cfg_write(REG_HALF_WIDTH, w);
    w = $urandom; w[SIZE_W-1:0]  = c.half_height;  cfg_write(REG_HALF_HEIGHT, w);
    w = $urandom; w[SIZE_W-1:0]  = c.corner_radius; cfg_write(REG_RADIUS, w);
    w = $urandom; w[MASK_W-1:0]  = c.round_mask;   cfg_write(REG_ROUND_MASK, w);
    cfg_write(REG_SPARE_LO, $urandom);
    cfg_write(REG_SPARE_HI, $urandom);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cur = c;
  endtask

  function automatic logic [SIZE_W-1:0] random_size();
    int k;
    k = $urandom_range(99);
    if (k < 60) return SIZE_W'($urandom_range(48));
    if (k < 85) return SIZE_W'($urandom_range(1023));
    return $urandom_range(1) ? '1 : '0;
  endfunction

  function automatic cfg_t random_shape();
    cfg_t c;
    int   rmax;
    c.centre_x    = ($urandom_range(3) == 0) ? COORD_W'($urandom)
                                             : COORD_W'($urandom_range(400) - 200);
    c.centre_y    = ($urandom_range(3) == 0) ? COORD_W'($urandom)
                                             : COORD_W'($urandom_range(400) - 200);
    c.half_width  = random_size();
    c.half_height = random_size();
    rmax = (c.half_width < c.half_height) ? int'(c.half_width) : int'(c.half_height);
    c.corner_radius = ($urandom_range(1) == 0) ? SIZE_W'($urandom_range(rmax))
                                               : random_size();
    c.round_mask  = MASK_W'($urandom);
    return c;
  endfunction

  // mostly around the corners and edges, some inside the box, some anywhere
  task automatic send_random_pixel();
    int k, rad, ax, ay;
    k = $urandom_range(99);
    rad = int'(cur.corner_radius);
    if (rad > int'(cur.half_width)) rad = int'(cur.half_width);
    if (rad > int'(cur.half_height)) rad = int'(cur.half_height);
    if (k < 55) begin
      ax = int'(cur.half_width) - rad - 3 + int'($urandom_range(rad + 6));
      ay = int'(cur.half_height) - rad - 3 + int'($urandom_range(rad + 6));
    end else begin
      ax = $urandom_range(int'(cur.half_width) + 4);
      ay = $urandom_range(int'(cur.half_height) + 4);
    end
    if (k < 80)
      send_offset($urandom_range(1) ? -ax : ax, $urandom_range(1) ? -ay : ay);
    else
      send_pixel(COORD_W'($urandom), COORD_W'($urandom));
  endtask

  initial begin
    rst_n         <= 1'b0;
    pix.valid     <= 1'b0;
    pix.pixel_x   <= '0;
    pix.pixel_y   <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    send_idle_pct = 33;
    recv_idle_pct = 47;
    cur = '{centre_x: '0, centre_y: '0, half_width: '0, half_height: '0,
            corner_radius: '0, round_mask: MASK_ALL_ROUND};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // reset shape: a point with every corner round
    send_offset(0, 0);
    send_offset(1, 1);

    // top-left and bottom-right round, the other two sharp
    drain();
    apply_cfg('{centre_x: 13'd100, centre_y: -13'sd50, half_width: 10'd20,
                half_height: 10'd12, corner_radius: 10'd6, round_mask: 4'b1001});
    send_offset(0, 0);
    send_offset(-18, -10);
    send_offset(-14, -6);
    send_offset(18, -10);
    send_offset(20, -12);
    send_offset(21, -12);
    send_offset(-20, 11);
    send_offset(17, 9);
    send_offset(19, 11);
    send_offset(18, 10);
    send_offset(0, 12);
    send_offset(0, -13);

    // radius above the smaller half size
    drain();
    apply_cfg('{centre_x: -13'sd7, centre_y: 13'd9, half_width: 10'd10,
                half_height: 10'd30, corner_radius: 10'd1000, round_mask: 4'hF});
    send_offset(9, 29);
    send_offset(-10, -25);
    send_offset(8, -28);

    // zero radius on round corners
    drain();
    apply_cfg('{centre_x: '0, centre_y: '0, half_width: 10'd8, half_height: 10'd8,
                corner_radius: 10'd0, round_mask: 4'hF});
    send_offset(8, 8);
    send_offset(9, 8);
    send_offset(-8, -9);

    // extreme centre and sizes, far pixels
    drain();
    apply_cfg('{centre_x: 13'h1000, centre_y: 13'h0FFF, half_width: 10'd1023,
                half_height: 10'd1023, corner_radius: 10'd1023, round_mask: 4'hF});
    send_pixel(13'h0FFF, 13'h1000);
    send_offset(0, 0);
    send_offset(300, -300);
    send_offset(724, -724);
    drain();
    apply_cfg('{centre_x: 13'h0FFF, centre_y: 13'h1000, half_width: 10'd1023,
                half_height: 10'd1023, corner_radius: 10'd1023, round_mask: 4'h0});
    send_pixel(13'h1000, 13'h0FFF);
    send_offset(-1023, 1023);

    for (int blk = 0; blk < 8; blk++) begin
      if (blk == 3) begin
        send_idle_pct = 47;
        recv_idle_pct = 33;
      end
      if (blk == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      drain();
      apply_cfg(random_shape());
      for (int n = 0; n < 100; n++) begin
        if (blk == 4 && n == 50) drain();
        send_random_pixel();
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (fails == 0 && pending == 0)
      $display("rounded_rect_pixel_coverage_test: PASS");
    else
      $display("rounded_rect_pixel_coverage_test: FAIL");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/rrpc_pkg.sv
rtl/core/rrpc_if.sv
rtl/core/rrpc_cfg.sv
rtl/core/rrpc_geom.sv
rtl/core/rrpc_root.sv
rtl/core/rounded_rect_pixel_coverage.sv
rtl/core/rrpc_chk.sv
tb/rrpc_cov_checker.sv
tb/rounded_rect_pixel_coverage_test.sv
